>>> rtl/gf2w_pkg.sv
// Shared types and constants for the GF(2^w) arithmetic unit.
package gf2w_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned POLY_W = 33;
    localparam int unsigned FW_W   = 6;

    localparam logic [1:0] REQ_MUL  = 2'd0;
    localparam logic [1:0] REQ_DIV  = 2'd1;
    localparam logic [1:0] REQ_INV  = 2'd2;
    localparam logic [1:0] REQ_RSVD = 2'd3;

    localparam logic [0:0] CFG_WIDTH = 1'd0;
    localparam logic [0:0] CFG_POLY  = 1'd1;

    localparam logic [FW_W-1:0]   FW_RESET   = 6'd8;
    localparam logic [POLY_W-1:0] POLY_RESET = 33'o435;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_INV,
        OP_DIV,
        OP_FIXED
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] fixed_result;
        logic              fixed_error;
    } task_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUILD,
        ST_FWD,
        ST_BWD,
        ST_MUL,
        ST_DONE
    } state_t;

endpackage

>>> rtl/gf2w_front.sv
// Front end: accept requests, mask operands and classify them.
module gf2w_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                req_type,
    input  logic [gf2w_pkg::DATA_W-1:0] operand_a,
    input  logic [gf2w_pkg::DATA_W-1:0] operand_b,
    input  logic [gf2w_pkg::DATA_W-1:0] mask,
    output logic                      q_valid,
    input  logic                      q_ready,
    output gf2w_pkg::task_t           q_task
);
    import gf2w_pkg::*;

    localparam int unsigned DEPTH = 2;

    task_t            fifo_reg [DEPTH];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;
    task_t            cls;
    logic [DATA_W-1:0] a, b;
    logic             push, pop;

    assign a = operand_a & mask;
    assign b = operand_b & mask;

    always_comb
    begin
        cls = '{op: OP_FIXED, a: a, b: b, fixed_result: '0, fixed_error: 1'b0};
        case (req_type)
            REQ_MUL: cls.op = OP_MUL;
            REQ_DIV:
            begin
                if (b == '0)
                    cls.fixed_error = 1'b1;
                else if (a != '0)
                    cls.op = OP_DIV;
            end
            REQ_INV:
            begin
                if (b == '0)
                    cls.fixed_error = 1'b1;
                else
                    cls.op = OP_INV;
            end
            default: cls.fixed_error = 1'b1;
        endcase
    end

    assign in_ready = (count_reg != 2'(DEPTH));
    assign q_valid  = (count_reg != 2'd0);
    assign q_task   = fifo_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= 2'(DEPTH))
        else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0) |-> !q_valid)
        else $error("queue empty but valid");
    assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 2'd1)
        else $error("push lost");

endmodule

>>> rtl/gf2w_back.sv
// Back end: shift-and-xor multiply, Gauss-elimination inverse, and divide as inverse then multiply.
module gf2w_back #(
    parameter int unsigned MAX_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [gf2w_pkg::FW_W-1:0]   width,
    input  logic [gf2w_pkg::POLY_W-1:0] poly,
    input  logic [gf2w_pkg::DATA_W-1:0] mask,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  gf2w_pkg::task_t             q_task,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [gf2w_pkg::DATA_W-1:0] out_result,
    output logic                        out_error
);
    import gf2w_pkg::*;

    localparam int unsigned IW = $clog2(MAX_WIDTH);

    logic [DATA_W-1:0] m_reg [MAX_WIDTH];
    logic [DATA_W-1:0] r_reg [MAX_WIDTH];
    state_t            state_reg, state_next;
    logic [IW-1:0]     i_reg, i_next;
    logic [IW-1:0]     j_reg, j_next;
    logic              swap_reg, swap_next;
    logic [DATA_W-1:0] cur_reg, cur_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] a_reg, a_next;
    logic              div_reg, div_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic              err_reg, err_next;
    logic [IW-1:0]     last;
    logic [DATA_W-1:0] bit_i, mi, ri, mj;
    logic [DATA_W-1:0] top;
    logic [DATA_W-1:0] cur_x;
    logic              m_we_build, m_we_j, m_we_i, r_we_j, r_we_i;
    logic [DATA_W-1:0] m_wd_j, r_wd_j, m_wd_i, r_wd_i;

    assign last  = IW'(width - 6'd1);
    assign bit_i = DATA_W'(1) << i_reg;
    assign mi    = m_reg[i_reg];
    assign ri    = r_reg[i_reg];
    assign mj    = m_reg[j_reg];
    assign top   = DATA_W'(1) << last;
    assign cur_x = (((cur_reg << 1) ^ ((cur_reg & top) != '0 ? poly[DATA_W-1:0] : '0))) & mask;

    assign q_ready    = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_result = res_reg;
    assign out_error  = err_reg;

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        swap_next      = swap_reg;
        cur_next       = cur_reg;
        acc_next       = acc_reg;
        a_next         = a_reg;
        div_next       = div_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_next       = res_reg;
        err_next       = err_reg;
        m_we_build     = 1'b0;
        m_we_j         = 1'b0;
        m_we_i         = 1'b0;
        r_we_j         = 1'b0;
        r_we_i         = 1'b0;
        m_wd_j         = mj ^ mi;
        r_wd_j         = r_reg[j_reg] ^ ri;
        m_wd_i         = mj;
        r_wd_i         = r_reg[j_reg];
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && q_ready)
                begin
                    a_next   = q_task.a;
                    cur_next = q_task.b;
                    acc_next = '0;
                    i_next   = '0;
                    div_next = (q_task.op == OP_DIV);
                    case (q_task.op)
                        OP_MUL:   state_next = ST_MUL;
                        OP_INV,
                        OP_DIV:   state_next = ST_BUILD;
                        default:
                        begin
                            res_next       = q_task.fixed_result;
                            err_next       = q_task.fixed_error;
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_BUILD:
            begin
                m_we_build = 1'b1;
                cur_next   = cur_x;
                i_next     = i_reg + IW'(1);
                if (i_reg == last)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    swap_next  = 1'b0;
                    state_next = ST_FWD;
                end
            end
            ST_FWD:
            begin
                if (!swap_reg)
                begin
                    if ((mi & bit_i) != '0)
                    begin
                        swap_next = 1'b1;
                        j_next    = i_reg + IW'(1);
                        if (i_reg == last)
                        begin
                            state_next = ST_BWD;
                            i_next     = last;
                            j_next     = '0;
                        end
                    end
                    else if (j_reg > i_reg && (mj & bit_i) != '0)
                    begin
                        m_we_i = 1'b1;
                        r_we_i = 1'b1;
                        m_we_j = 1'b1;
                        r_we_j = 1'b1;
                        m_wd_j = mi;
                        r_wd_j = ri;
                    end
                    else if (j_reg == last || i_reg == last)
                    begin
                        res_next       = '0;
                        err_next       = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                        j_next = (j_reg > i_reg) ? j_reg + IW'(1) : i_reg + IW'(1);
                end
                else
                begin
                    if ((mj & bit_i) != '0)
                    begin
                        m_we_j = 1'b1;
                        r_we_j = 1'b1;
                    end
                    if (j_reg == last)
                    begin
                        swap_next = 1'b0;
                        i_next    = i_reg + IW'(1);
                        j_next    = '0;
                    end
                    else
                        j_next = j_reg + IW'(1);
                end
            end
            ST_BWD:
            begin
                if (i_reg == '0)
                begin
                    cur_next = ri;
                    acc_next = '0;
                    if (div_reg)
                    begin
                        i_next     = '0;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        res_next       = ri & mask;
                        err_next       = 1'b0;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    if ((mj & bit_i) != '0)
                        r_we_j = 1'b1;
                    if (j_reg == i_reg - IW'(1))
                    begin
                        i_next = i_reg - IW'(1);
                        j_next = '0;
                    end
                    else
                        j_next = j_reg + IW'(1);
                end
            end
            ST_MUL:
            begin
                if (a_reg[i_reg])
                    acc_next = acc_reg ^ cur_reg;
                cur_next = cur_x;
                i_next   = i_reg + IW'(1);
                if (i_reg == last)
                begin
                    res_next       = a_reg[i_reg] ? acc_reg ^ cur_reg : acc_reg;
                    err_next       = 1'b0;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (m_we_build)
        begin
            m_reg[i_reg] <= cur_reg;
            r_reg[i_reg] <= DATA_W'(1) << i_reg;
        end
        if (m_we_i)
            m_reg[i_reg] <= m_wd_i;
        if (r_we_i)
            r_reg[i_reg] <= r_wd_i;
        if (m_we_j)
            m_reg[j_reg] <= m_wd_j;
        if (r_we_j)
            r_reg[j_reg] <= r_wd_j;
        i_reg    <= i_next;
        j_reg    <= j_next;
        cur_reg  <= cur_next;
        acc_reg  <= acc_next;
        a_reg    <= a_next;
        div_reg  <= div_next;
        swap_reg <= swap_next;
        res_reg  <= res_next;
        err_reg  <= err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_result) && $stable(out_error))
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_error |-> out_result == '0)
        else $error("error with nonzero result");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !q_ready)
        else $error("accept while busy");

endmodule

>>> rtl/gf2w_arithmetic_unit.sv
// Multiply is a shift-and-xor over the bits of a; inverse builds the rows, then runs forward
// elimination with row swaps and back substitution; divide runs the inverse and then a multiply.
// Throughput: one item at a time in the back end; a two-entry queue lets the front end keep
// accepting while the elimination sequencer runs.
// Reset: rst_n clears control and queue and sets field_width 8, reduce_poly 0435.
module gf2w_arithmetic_unit #(
    parameter int unsigned MAX_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // operand_a[31:0], operand_b[63:32]
    input  logic [1:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // result
    output logic        m_axis_tuser,   // error
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [32:0] cfg_data
);
    import gf2w_pkg::*;

    logic [FW_W-1:0]   fw_reg;
    logic [POLY_W-1:0] poly_reg;
    logic [FW_W-1:0]   width;
    logic [DATA_W-1:0] mask;
    logic              q_valid, q_ready;
    task_t             q_task;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg   <= FW_RESET;
            poly_reg <= POLY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WIDTH: fw_reg   <= cfg_data[FW_W-1:0];
                CFG_POLY:  poly_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        if (fw_reg == '0)
            width = FW_W'(1);
        else if (fw_reg > FW_W'(MAX_WIDTH))
            width = FW_W'(MAX_WIDTH);
        else
            width = fw_reg;
        mask = DATA_W'((64'd1 << width) - 64'd1);
    end

    gf2w_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .req_type  (s_axis_tuser),
        .operand_a (s_axis_tdata[31:0]),
        .operand_b (s_axis_tdata[63:32]),
        .mask      (mask),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_task    (q_task)
    );

    gf2w_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .width      (width),
        .poly       (poly_reg),
        .mask       (mask),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_task     (q_task),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (m_axis_tdata),
        .out_error  (m_axis_tuser)
    );

endmodule

>>> sim/gf2w_arithmetic_unit_test.sv
// Self-checking testbench for the GF(2^w) multiply, divide and inverse unit.
`timescale 1ns / 1ps

module gf2w_arithmetic_unit_test;
    import gf2w_pkg::*;

    typedef struct packed {
        logic [31:0] value;
        logic        err;
    } field_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [32:0] cfg_data;

    logic [5:0]    width_reg;
    logic [32:0]   poly_reg;
    field_result_t expected_results[$];
    int            fail_count;
    bit            no_idle;

    gf2w_arithmetic_unit u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic int unsigned eff_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > 32)
            return 32;
        return {26'd0, width_reg};
    endfunction

    function automatic logic [63:0] mask_of(int unsigned w);
        return (64'd1 << w) - 64'd1;
    endfunction

    function automatic logic [63:0] shift_x(logic [63:0] v, int unsigned w);
        if (v[w-1])
            return ((v << 1) ^ {31'd0, poly_reg}) & mask_of(w);
        return (v << 1) & mask_of(w);
    endfunction

    function automatic logic [63:0] gf_mul(logic [63:0] a, logic [63:0] b, int unsigned w);
        logic [63:0] acc;
        logic [63:0] cur;
        acc = 0;
        cur = b;
        for (int i = 0; i < w; i++)
        begin
            if (a[i])
                acc ^= cur;
            cur = shift_x(cur, w);
        end
        return acc;
    endfunction

    function automatic logic [63:0] gf_inv(logic [63:0] b, int unsigned w, output bit ok);
        logic [63:0] m[32];
        logic [63:0] r[32];
        logic [63:0] t;
        int          j;
        ok = 1'b0;
        for (int i = 0; i < w; i++)
        begin
            m[i] = b;
            r[i] = 64'd1 << i;
            b = shift_x(b, w);
        end
        for (int i = 0; i < w; i++)
        begin
            if (!m[i][i])
            begin
                j = i + 1;
                while (j < w && !m[j][i])
                    j++;
                if (j >= w)
                    return 0;
                t = m[i]; m[i] = m[j]; m[j] = t;
                t = r[i]; r[i] = r[j]; r[j] = t;
            end
            for (int k = i + 1; k < w; k++)
                if (m[k][i])
                begin
                    m[k] ^= m[i];
                    r[k] ^= r[i];
                end
        end
        for (int i = w - 1; i >= 0; i--)
            for (int k = 0; k < i; k++)
                if (m[k][i])
                    r[k] ^= r[i];
        ok = 1'b1;
        return r[0] & mask_of(w);
    endfunction

    function automatic field_result_t field_compute(logic [1:0] req, logic [31:0] a_in,
                                                    logic [31:0] b_in);
        field_result_t res;
        int unsigned   w;
        logic [63:0]   a;
        logic [63:0]   b;
        logic [63:0]   ib;
        bit            ok;
        w = eff_width();
        a = {32'd0, a_in} & mask_of(w);
        b = {32'd0, b_in} & mask_of(w);
        res = '0;
        if (req == REQ_MUL)
            res.value = 32'(gf_mul(a, b, w));
        else if (req == REQ_DIV)
        begin
            if (b == 0)
                res.err = 1'b1;
            else if (a != 0)
            begin
                ib = gf_inv(b, w, ok);
                if (ok)
                    res.value = 32'(gf_mul(a, ib, w));
                else
                    res.err = 1'b1;
            end
        end
        else if (req == REQ_INV)
        begin
            if (b == 0)
                res.err = 1'b1;
            else
            begin
                ib = gf_inv(b, w, ok);
                if (ok)
                    res.value = ib[31:0];
                else
                    res.err = 1'b1;
            end
        end
        else
            res.err = 1'b1;
        return res;
    endfunction

    task automatic send_request(logic [1:0] req, logic [31:0] a, logic [31:0] b);
        if (!no_idle && $urandom_range(99) < 13)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 13);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tuser  <= req;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_results.push_back(field_compute(req, a, b));
    endtask

    task automatic write_reg(logic [0:0] idx, logic [32:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WIDTH)
            width_reg = value[5:0];
        else
            poly_reg = value;
        @(posedge clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
    endtask

    task automatic set_field(logic [32:0] w, logic [32:0] poly);
        drain_results();
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_POLY, poly);
    endtask

    function automatic logic [31:0] rand_word(int unsigned w);
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'd1;
            default: return ($urandom_range(3) == 0) ? v : v & 32'(mask_of(w));
        endcase
    endfunction

    task automatic test_directed();
        logic [1:0] req;
        for (int r = 0; r < 4; r++)
        begin
            req = 2'(r);
            send_request(req, 32'h0, 32'h0);
            send_request(req, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            send_request(req, 32'h0, 32'h53);
            send_request(req, 32'hCA, 32'h1);
        end
        send_request(REQ_DIV, 32'hAAAA_5555, 32'h5555_AAAA);
        send_request(REQ_INV, 32'h0, 32'h8000_0002);
    endtask

    task automatic test_random(int n_items);
        logic [1:0] req;
        for (int i = 0; i < n_items; i++)
        begin
            req = ($urandom_range(19) == 0) ? REQ_RSVD : 2'($urandom_range(2));
            send_request(req, rand_word(eff_width()), rand_word(eff_width()));
        end
    endtask

    task automatic test_field_settings();
        set_field(33'd32, 33'h1_0040_0007);
        test_directed();
        test_random(60);
        set_field(33'd1, 33'h3);
        test_random(30);
        set_field(33'd0, 33'h1_FFFF_FFFF);
        test_random(20);
        set_field(33'd63, 33'h0_0000_008D);
        test_random(30);
        set_field(33'd4, 33'h13);
        test_random(50);
        set_field(33'd4, 33'h15);
        test_random(50);
        set_field(33'd16, 33'h1100B);
        test_random(70);
        no_idle = 1'b1;
        set_field(33'd2, 33'h7);
        test_random(60);
        no_idle = 1'b0;
        set_field(33'd12, {1'b0, $urandom()});
        test_random(60);
        set_field(33'd24, {1'b1, 32'h0000_0087});
        test_random(40);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t unexpected transfer: result %h error %b", $time,
                             m_axis_tdata, m_axis_tuser);
                    fail_count++;
                end
                else
                begin
                    if (m_axis_tdata !== expected_results[0].value)
                    begin
                        $display("%0t result mismatch: expected %h actual %h", $time,
                                 expected_results[0].value, m_axis_tdata);
                        fail_count++;
                    end
                    if (m_axis_tuser !== expected_results[0].err)
                    begin
                        $display("%0t error mismatch: expected %b actual %b", $time,
                                 expected_results[0].err, m_axis_tuser);
                        fail_count++;
                    end
                    void'(expected_results.pop_front());
                end
            end
            m_axis_tready <= no_idle || ($urandom_range(99) >= 13);
        end
    end

    initial
    begin
        #20_000_000;
        $display("FAIL gf2w_arithmetic_unit");
        $finish;
    end

    initial
    begin
        fail_count    = 0;
        no_idle       = 1'b0;
        width_reg     = FW_RESET;
        poly_reg      = POLY_RESET;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(60);
        test_field_settings();
        drain_results();
        if (fail_count == 0)
            $display("PASS gf2w_arithmetic_unit");
        else
            $display("FAIL gf2w_arithmetic_unit");
        $finish;
    end
endmodule
